// ----- design/nsdq_pkg.sv -----
package nsdq_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 24;
    localparam int RES_W = 26;      // floor/ceil candidates, wide enough before saturation
    localparam int BIN_W = 26;      // digit bins, unsigned Q10.16
    localparam int BIN_N = 9;

    // dither_mode codes
    localparam logic [2:0] MODE_TAN24     = 3'd0;
    localparam logic [2:0] MODE_TIMBERS24 = 3'd1;
    localparam logic [2:0] MODE_BENFORD24 = 3'd2;
    localparam logic [2:0] MODE_TAN16     = 3'd3;
    localparam logic [2:0] MODE_TIMBERS16 = 3'd4;
    localparam logic [2:0] MODE_BENFORD16 = 3'd5;

    // shaping gains, Q.16
    localparam logic signed [16:0] GAIN_TAN     = 17'sd52429;
    localparam logic signed [16:0] GAIN_TIMBERS = 17'sd7209;
    localparam int                 ROUND_HALF   = 32768;

    // bin arithmetic
    localparam logic [26:0] BIN_ONE    = 27'd65536;
    localparam logic [26:0] BIN_CUT    = 27'd64290816;   // 981.0: bin + 1.0 above 982.0
    localparam logic [26:0] BIN_MAX    = 27'd67108863;
    localparam logic [15:0] BIN_DECAY  = 16'd64881;      // 0.99
    localparam logic [30:0] BIN_TOTAL  = 31'd65470464;   // 1000.0 - 1.0

    localparam logic [BIN_W-1:0] BIN_RESET [BIN_N] = '{
        26'd19726336, 26'd11534336, 26'd8192000, 26'd6356992, 26'd5177344,
        26'd4390912,  26'd3801088,  26'd3342336, 26'd3014656
    };

    localparam logic [RES_W-1:0] OUT24_HI = 26'sd8388607;
    localparam logic [RES_W-1:0] OUT24_LO = -26'sd8388608;
    localparam logic [RES_W-1:0] OUT16_HI = 26'sd32767;
    localparam logic [RES_W-1:0] OUT16_LO = -26'sd32768;

    localparam logic [26:0] POW10 [8] = '{
        27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
        27'd1000000, 27'd10000000
    };

    typedef logic [BIN_W-1:0] t_bin;

    typedef struct packed {
        logic fire;      // item moves from input stage to result stage
        logic low16;
        logic benford;
        logic timbers;
    } t_step_ctl;

    // leading decimal digit, 0 when n < 1
    function automatic logic [3:0] lead_digit(input logic signed [RES_W-1:0] n);
        logic [26:0] u;
        logic [26:0] p10;
        logic [2:0]  dec;
        logic [3:0]  dig;
        u   = {1'b0, n};
        dec = '0;
        for (int k = 1; k < 8; k++) begin
            if (u >= POW10[k]) dec = 3'(k);
        end
        p10 = POW10[dec];
        dig = 4'd1;
        for (int d = 2; d < 10; d++) begin
            if (u >= 27'(d) * p10) dig = 4'(d);
        end
        if (n < 1) dig = '0;
        return dig;
    endfunction

endpackage

// ----- design/nsdq_in_if.sv -----
interface nsdq_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [nsdq_pkg::IN_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- design/nsdq_out_if.sv -----
interface nsdq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [nsdq_pkg::OUT_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- design/nsdq_shaper.sv -----
module nsdq_shaper #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsdq_pkg::t_step_ctl       i_ctl,
    input  logic signed [FRAC_BITS+23:0] i_x,
    input  logic signed [FRAC_BITS+24:0] i_ns,
    output logic signed [FRAC_BITS+24:0] o_p,
    output logic                      o_down
);
    localparam int XW  = FRAC_BITS + 24;
    localparam int NSW = XW + 1;
    localparam int MW  = NSW + 17;

    logic signed [XW-1:0] r_prev;
    logic signed [XW:0]   r_older;
    logic signed [XW-1:0] n_prev;
    logic signed [XW:0]   n_older;

    logic signed [16:0]   gain;
    logic signed [MW-1:0] prod;
    logic signed [MW-1:0] prod_rnd;
    logic signed [XW+1:0] p_wide;
    logic signed [XW+1:0] two_p;
    logic signed [XW+1:0] bend_sum;

    assign gain     = i_ctl.timbers ? nsdq_pkg::GAIN_TIMBERS : nsdq_pkg::GAIN_TAN;
    assign prod     = MW'(i_ns) * MW'(gain);
    assign prod_rnd = prod + MW'(nsdq_pkg::ROUND_HALF);
    assign p_wide   = (XW+2)'(r_prev) - (XW+2)'(prod_rnd >>> 16);
    assign o_p      = p_wide[XW:0];

    assign two_p    = {o_p, 1'b0};
    assign bend_sum = (XW+2)'(i_x) + (XW+2)'(r_older);
    assign o_down   = i_ctl.timbers ? (two_p >= bend_sum) : (two_p <= bend_sum);

    always_comb begin
        n_prev  = r_prev;
        n_older = r_older;
        if (i_ctl.fire && !i_ctl.benford) begin
            n_prev  = i_x;
            n_older = o_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_older <= '0;
        end else begin
            r_prev  <= n_prev;
            r_older <= n_older;
        end
    end

endmodule

// ----- design/nsdq_benford.sv -----
module nsdq_benford (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nsdq_pkg::t_step_ctl                 i_ctl,
    input  logic signed [nsdq_pkg::RES_W-1:0]   i_floor,
    input  logic                                i_exact,
    output logic                                o_pick_up
);
    nsdq_pkg::t_bin r_bin [nsdq_pkg::BIN_N];
    nsdq_pkg::t_bin n_bin [nsdq_pkg::BIN_N];

    logic signed [nsdq_pkg::RES_W-1:0] ceil_v;
    logic [3:0]          dig_a;
    logic [3:0]          dig_b;
    logic [3:0]          dig_win;
    logic [29:0]         bin_sum;
    logic signed [30:0]  total;
    logic signed [30:0]  score_a;
    logic signed [30:0]  score_b;
    logic                pick_a;
    logic                cut;
    logic [26:0]         inc_v  [nsdq_pkg::BIN_N];
    logic [42:0]         dec_v  [nsdq_pkg::BIN_N];
    logic [26:0]         post_v [nsdq_pkg::BIN_N];

    assign ceil_v  = i_exact ? i_floor : i_floor + {{(nsdq_pkg::RES_W-1){1'b0}}, 1'b1};
    assign dig_a   = nsdq_pkg::lead_digit(i_floor);
    assign dig_b   = nsdq_pkg::lead_digit(ceil_v);

    assign bin_sum = ((30'(r_bin[0]) + 30'(r_bin[1])) + (30'(r_bin[2]) + 30'(r_bin[3])))
                   + ((30'(r_bin[4]) + 30'(r_bin[5])) + (30'(r_bin[6]) + 30'(r_bin[7])))
                   + 30'(r_bin[8]);
    assign total   = $signed(nsdq_pkg::BIN_TOTAL) - $signed({1'b0, bin_sum});
    assign score_a = (dig_a != '0) ? total : '0;
    assign score_b = (dig_b != '0) ? total : '0;
    assign pick_a  = score_a < score_b;
    assign dig_win = pick_a ? dig_a : dig_b;
    assign o_pick_up = !pick_a;

    always_comb begin
        cut = 1'b0;
        for (int i = 0; i < nsdq_pkg::BIN_N; i++) begin
            if (((dig_a == 4'(i + 1)) || (dig_b == 4'(i + 1)))
                && ({1'b0, r_bin[i]} > nsdq_pkg::BIN_CUT)) begin
                cut = 1'b1;
            end
        end
        for (int i = 0; i < nsdq_pkg::BIN_N; i++) begin
            inc_v[i] = {1'b0, r_bin[i]} + ((dig_win == 4'(i + 1)) ? nsdq_pkg::BIN_ONE : '0);
            dec_v[i] = (43'(inc_v[i]) * 43'(nsdq_pkg::BIN_DECAY) + 43'(nsdq_pkg::ROUND_HALF)) >> 16;
            post_v[i] = cut ? dec_v[i][26:0] : inc_v[i];
            if (post_v[i] > nsdq_pkg::BIN_MAX) post_v[i] = nsdq_pkg::BIN_MAX;
            n_bin[i] = (i_ctl.fire && i_ctl.benford) ? post_v[i][nsdq_pkg::BIN_W-1:0] : r_bin[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= nsdq_pkg::BIN_RESET;
        end else begin
            r_bin <= n_bin;
        end
    end

endmodule

// ----- design/noise_shaped_dither_quantizer.sv -----
// Noise-shaped requantizer: 32-bit full-scale samples in, 24- or 16-bit integers out.
// Channels: i_in carries one sample_in per beat, o_out one sample_out per beat;
//   a beat moves at a rising edge with valid and ready both high.
// Config: i_cfg_we/i_cfg_data write dither_mode (0..2 tan/timbers/benford at 24 bit,
//   3..5 the same at 16 bit, 6 and 7 act as benford at 24 bit). Write it only while idle.
// Pipeline: input register -> one compute pass -> result register.
//   A beat waits in the input register until the result register is free or being drained.
//   Throughput: one sample per cycle unless o_out stalls. The shaping state (noise
//   accumulator, sample history, digit bins) closes its loop inside the single compute
//   pass, so each sample sees the state left by the one before it.
// Stall: with o_out held, one more sample parks in the input register; i_in.ready
//   drops only when both registers are full. A stalled result holds its value.
// Reset (i_rst_n low, synchronous): both stages empty, mode 0, noise accumulator
//   and history zero, digit bins back to their Benford counts. No clearing pass.
// 16-bit results are sign-extended onto the 24-bit port.
module noise_shaped_dither_quantizer #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nsdq_in_if.sink          i_in,
    nsdq_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_data
);
    localparam int XW    = FRAC_BITS + 24;   // scaled input
    localparam int NSW   = XW + 1;           // noise accumulator, clamped to |x| or, for benford, |x - ns|
    localparam int WW    = XW + 3;           // working width for w, clamp
    localparam int SH24  = FRAC_BITS - 8;
    localparam int L16   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int R16   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int RES_W = nsdq_pkg::RES_W;

    // handshake / stage registers
    logic                               r_in_valid;
    logic signed [nsdq_pkg::IN_W-1:0]   r_in_sample;
    logic                               r_out_valid;
    logic signed [nsdq_pkg::OUT_W-1:0]  r_out_sample;
    logic [2:0]                         r_mode;
    logic signed [NSW-1:0]              r_ns;
    logic signed [NSW-1:0]              n_ns;
    logic signed [nsdq_pkg::OUT_W-1:0]  n_out_sample;

    logic                 fire;
    nsdq_pkg::t_step_ctl  ctl;

    logic signed [XW-1:0]    x_ext;
    logic signed [XW-1:0]    x24;
    logic signed [XW-1:0]    x16;
    logic signed [XW-1:0]    x;
    logic signed [WW-1:0]    w_b;        // benford working value x - ns
    logic signed [RES_W-1:0] floor_b;
    logic                    exact_b;
    logic                    up_b;

    logic signed [XW:0]      p;
    logic                    down;
    logic signed [RES_W-1:0] floor_p;

    logic signed [RES_W-1:0] base;
    logic                    up;
    logic signed [RES_W-1:0] res;
    logic signed [RES_W-1:0] res_sat;
    logic [FRAC_BITS-1:0]    frac;
    logic signed [WW-1:0]    delta;
    logic signed [WW-1:0]    ns_pre;
    logic signed [WW-1:0]    w_sel;
    logic signed [WW-1:0]    mag;
    logic signed [WW-1:0]    ns_clamped;
    logic signed [RES_W-1:0] hi;
    logic signed [RES_W-1:0] lo;

    // result stage takes the input stage whenever it is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;

    // mode decode
    always_comb begin
        ctl.fire = fire;
        unique case (r_mode)
            nsdq_pkg::MODE_TAN24: begin
                ctl.low16 = 1'b0; ctl.benford = 1'b0; ctl.timbers = 1'b0;
            end
            nsdq_pkg::MODE_TIMBERS24: begin
                ctl.low16 = 1'b0; ctl.benford = 1'b0; ctl.timbers = 1'b1;
            end
            nsdq_pkg::MODE_TAN16: begin
                ctl.low16 = 1'b1; ctl.benford = 1'b0; ctl.timbers = 1'b0;
            end
            nsdq_pkg::MODE_TIMBERS16: begin
                ctl.low16 = 1'b1; ctl.benford = 1'b0; ctl.timbers = 1'b1;
            end
            nsdq_pkg::MODE_BENFORD16: begin
                ctl.low16 = 1'b1; ctl.benford = 1'b1; ctl.timbers = 1'b0;
            end
            default: begin    // benford 24 bit, also the two spare codes
                ctl.low16 = 1'b0; ctl.benford = 1'b1; ctl.timbers = 1'b0;
            end
        endcase
    end

    // scale to FRAC_BITS below the target LSB; right shifts floor
    assign x_ext = XW'(r_in_sample);
    assign x24   = x_ext <<< SH24;
    assign x16   = (x_ext <<< L16) >>> R16;
    assign x     = ctl.low16 ? x16 : x24;

    // benford candidates
    assign w_b     = WW'(x) - WW'(r_ns);
    assign floor_b = RES_W'(w_b >>> FRAC_BITS);
    assign exact_b = (w_b[FRAC_BITS-1:0] == '0);

    nsdq_benford u_benford (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_floor   (floor_b),
        .i_exact   (exact_b),
        .o_pick_up (up_b)
    );

    nsdq_shaper #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shaper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_x     (x),
        .i_ns    (r_ns),
        .o_p     (p),
        .o_down  (down)
    );

    assign floor_p = RES_W'(p >>> FRAC_BITS);

    // pick floor or floor+1; the noise update is built from the rounding error of that pick
    always_comb begin
        base  = ctl.benford ? floor_b : floor_p;
        up    = ctl.benford ? up_b : !down;
        frac  = ctl.benford ? w_b[FRAC_BITS-1:0] : p[FRAC_BITS-1:0];
        res   = base + RES_W'(up);
        delta = up ? (WW'(1) <<< FRAC_BITS) - WW'({1'b0, frac}) : -WW'({1'b0, frac});
        // benford: out*one - w; shapers: ns + out*one - p
        ns_pre = ctl.benford ? delta : WW'(r_ns) + delta;
        w_sel  = ctl.benford ? w_b : WW'(x);
        mag    = (w_sel < 0) ? -w_sel : w_sel;
        ns_clamped = ns_pre;
        if (ns_pre > mag) ns_clamped = mag;
        if (ns_pre < -mag) ns_clamped = -mag;
        n_ns = fire ? ns_clamped[NSW-1:0] : r_ns;

        hi = ctl.low16 ? nsdq_pkg::OUT16_HI : nsdq_pkg::OUT24_HI;
        lo = ctl.low16 ? nsdq_pkg::OUT16_LO : nsdq_pkg::OUT24_LO;
        res_sat = res;
        if (res > hi) res_sat = hi;
        if (res < lo) res_sat = lo;
        n_out_sample = res_sat[nsdq_pkg::OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= nsdq_pkg::MODE_TAN24;
            r_ns        <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_ns <= n_ns;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= i_in.sample_in;
        end
        if (fire) begin
            r_out_sample <= n_out_sample;
        end
    end

endmodule

// ----- design/nsdq_checker.sv -----
module nsdq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [nsdq_pkg::OUT_W-1:0]         i_out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty result stage never back-pressures the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // a rising result valid needs input ready or an input beat before it
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_ready) || $past(i_in_valid && i_in_ready, 2))
        else $error("result beat without an input beat");

endmodule

bind noise_shaped_dither_quantizer nsdq_checker u_nsdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sample_out)
);
